/* src/bfc_pkg.sv */
// bfc_pkg: shared constants and types for the block fir convolver
// no dependencies; imported by bfc_cell, bfc_ctrl and block_fir_convolver
`default_nettype none

package bfc_pkg;

	localparam int MAX_TAPS_DEF = 16;
	localparam int SMP_W        = 16;
	localparam int PROD_W       = 2 * SMP_W;
	localparam int FRAC_BITS    = 15;
	localparam int TAP_IDX_W    = 4;
	localparam int KL_W         = 5;
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 3;

	localparam logic [KL_W-1:0] KL_RESET = KL_W'(1);

	localparam logic OP_WRITE_TAP = 1'b0;
	localparam logic OP_SAMPLE    = 1'b1;

	localparam logic REG_KERNEL_LENGTH = 1'b0;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	typedef struct packed {
		logic tap_wr;
		logic smp_load;
		logic launch;
	} bfc_ctl_t;

endpackage

`default_nettype wire

/* src/bfc_cell.sv */
// bfc_cell: one tap of the convolver row, holding a coefficient and one history sample
// depends on bfc_pkg; a chain of these is built in block_fir_convolver
`default_nettype none

module bfc_cell
	import bfc_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   tap_we,
	input  wire logic signed [SMP_W-1:0]                tap_wdata,
	input  wire logic                                   load,
	input  wire logic                                   clr,
	input  wire logic signed [SMP_W-1:0]                smp_in,
	output logic signed [SMP_W-1:0]                     smp_out,
	input  wire logic                                   en,
	input  wire logic                                   tok_in,
	input  wire logic signed [PROD_W+$clog2(MAX_TAPS)-1:0] acc_in,
	output logic                                        tok_out,
	output logic signed [PROD_W+$clog2(MAX_TAPS)-1:0]   acc_out
);

	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

	logic signed [SMP_W-1:0]  tap_q;
	logic signed [SMP_W-1:0]  smp_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			smp_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (tap_we) begin
				tap_q <= tap_wdata;
			end
			if (load) begin
				smp_q <= clr ? '0 : smp_in;
			end
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= en ? ($signed(PROD_W'(smp_q)) * $signed(PROD_W'(tap_q))) : '0;
		acc_q  <= acc_in + ACC_W'(prod_q);
	end

	assign smp_out = smp_q;
	assign tok_out = tok_q;
	assign acc_out = acc_q;

endmodule

`default_nettype wire

/* src/bfc_ctrl.sv */
// bfc_ctrl: input handshake, launch timing, rounding and saturation, output buffering
// depends on bfc_pkg; drives the cell row of block_fir_convolver
`default_nettype none

module bfc_ctrl
	import bfc_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   op,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [SMP_W-1:0]                     sample_out,
	output logic                                        clipped,
	input  wire logic                                   done,
	input  wire logic signed [PROD_W+$clog2(MAX_TAPS)-1:0] acc_fin,
	output bfc_ctl_t                                    ctl
);

	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
	localparam int Q_W   = ACC_W - FRAC_BITS;

	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SMP_MAX);
	localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SMP_MIN);

	logic                    busy_q;
	logic                    l1_q;
	logic                    l2_q;
	logic                    out_valid_q;
	logic                    pend_valid_q;
	logic signed [SMP_W-1:0] out_smp_q;
	logic                    out_clip_q;
	logic signed [SMP_W-1:0] pend_smp_q;
	logic                    pend_clip_q;

	logic                    accept;
	logic                    take;
	logic                    to_out;
	logic signed [Q_W-1:0]   q;
	logic signed [SMP_W-1:0] res_smp;
	logic                    res_clip;

	assign in_ready     = !busy_q && !pend_valid_q;
	assign accept       = in_valid && in_ready;
	assign ctl.tap_wr   = accept && (op == OP_WRITE_TAP);
	assign ctl.smp_load = accept && (op == OP_SAMPLE);
	assign ctl.launch   = l2_q;

	assign take   = out_valid_q && out_ready;
	assign to_out = !out_valid_q || take;

	always_comb begin
		q = Q_W'(acc_fin >>> FRAC_BITS);
		if (q > Q_MAX) begin
			res_smp  = SMP_MAX;
			res_clip = 1'b1;
		end else if (q < Q_MIN) begin
			res_smp  = SMP_MIN;
			res_clip = 1'b1;
		end else begin
			res_smp  = q[SMP_W-1:0];
			res_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			l1_q         <= 1'b0;
			l2_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			l1_q <= ctl.smp_load;
			l2_q <= l1_q;
			if (ctl.smp_load) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				if (to_out) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (to_out) begin
				out_smp_q  <= res_smp;
				out_clip_q <= res_clip;
			end else begin
				pend_smp_q  <= res_smp;
				pend_clip_q <= res_clip;
			end
		end else if (take && pend_valid_q) begin
			out_smp_q  <= pend_smp_q;
			out_clip_q <= pend_clip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_smp_q;
	assign clipped    = out_clip_q;

	// accumulator only leaves the row for a sample in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result left the cell row with no sample in flight");

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without a result in the output register");

	a_stall_to_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid_q && !out_ready) |=> pend_valid_q)
		else $error("stalled result was not held");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.smp_load |=> (busy_q && !in_ready))
		else $error("input taken while the cell row is working");

endmodule

`default_nettype wire

/* src/block_fir_convolver.sv */
// Block FIR convolver: a tap write (op 0) sets one tap and gives no result.
// A sample (op 1) shifts the history row (block_start clears all but the new
// sample), forms all tap products in parallel and, once the launch has passed
// the l1 and l2 registers, carries one accumulator down the row of MAX_TAPS cells,
// one cell per cycle; the result is registered at the output. The next item is
// taken only once the result has left the row. One finished result can wait
// at the output while the next sample is being worked on; a second finished result
// holds the input off until the output transaction is taken. The sum is shifted right
// by 15 (toward minus infinity) and saturated to 16 bits, clipped flagging it.
// Depends on bfc_pkg, bfc_cell and bfc_ctrl.
`default_nettype none

module block_fir_convolver
	import bfc_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     op,
	input  wire logic [TAP_IDX_W-1:0]     tap_index,
	input  wire logic signed [SMP_W-1:0]  tap_value,
	input  wire logic signed [SMP_W-1:0]  sample_in,
	input  wire logic                     block_start,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [SMP_W-1:0]       sample_out,
	output logic                          clipped
);

	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

	logic [KL_W-1:0]         kl_q;
	logic                    reg_sel;
	bfc_ctl_t                ctl;
	logic signed [SMP_W-1:0] smp_chain [MAX_TAPS];
	logic                    tok_chain [MAX_TAPS+1];
	logic signed [ACC_W-1:0] acc_chain [MAX_TAPS+1];

	// register file
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kl_q <= KL_RESET;
		end else if (psel && penable && pwrite && pready && (reg_sel == REG_KERNEL_LENGTH)) begin
			kl_q <= pwdata[KL_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_KERNEL_LENGTH) ? APB_DW'(kl_q) : '0;

	bfc_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped),
		.done       (tok_chain[MAX_TAPS]),
		.acc_fin    (acc_chain[MAX_TAPS]),
		.ctl        (ctl)
	);

	assign tok_chain[0] = ctl.launch;
	assign acc_chain[0] = '0;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic                    tap_we;
		logic                    en;
		logic                    clr;
		logic signed [SMP_W-1:0] smp_src;

		assign tap_we = ctl.tap_wr && (int'(tap_index) == k);
		assign en     = (k == 0) || (int'(kl_q) > k);

		if (k == 0) begin : g_head
			assign smp_src = sample_in;
			assign clr     = 1'b0;
		end else begin : g_body
			assign smp_src = smp_chain[k-1];
			assign clr     = block_start;
		end

		bfc_cell #(
			.MAX_TAPS (MAX_TAPS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tap_we    (tap_we),
			.tap_wdata (tap_value),
			.load      (ctl.smp_load),
			.clr       (clr),
			.smp_in    (smp_src),
			.smp_out   (smp_chain[k]),
			.en        (en),
			.tok_in    (tok_chain[k]),
			.acc_in    (acc_chain[k]),
			.tok_out   (tok_chain[k+1]),
			.acc_out   (acc_chain[k+1])
		);
	end

endmodule

`default_nettype wire
